FILE: src/grj_pkg.sv
// Shared constants, codes and helpers for the Gaussian residual/Jacobian block.
// No dependencies; used by gaussian_residual_jacobian.
`default_nettype none
package grj_pkg;

    localparam int EXP_FRAC    = 30;   // fraction bits of the exponential table
    localparam int TAB_W       = 31;   // table entry width, holds 1.0 in Q30
    localparam int Z_LIMIT_LOG = 3;    // |z| range of the table is 2^3 = 8
    localparam int OUT_W       = 32;   // result word width
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_ENABLE = 8'd3;

    localparam logic [1:0] FAULT_OK     = 2'd0;
    localparam logic [1:0] FAULT_NONPOS = 2'd1;
    localparam logic [1:0] FAULT_SAT    = 2'd2;

    localparam logic [OUT_W-1:0] LIM_POS = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] LIM_NEG = 32'h8000_0000;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } fin_t;

    // Rounded Q30 product.
    function automatic logic [63:0] rmul30(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] p;
        p = a * b + (64'd1 << (EXP_FRAC - 1));
        return p >> EXP_FRAC;
    endfunction

    // Clamp a quotient magnitude and apply the sign.
    function automatic fin_t finish(input logic [OUT_W-1:0] q, input logic over,
                                    input logic neg);
        fin_t        r;
        logic [OUT_W-1:0] lim;
        logic [OUT_W-1:0] v;
        lim   = neg ? LIM_NEG : LIM_POS;
        r.sat = over || (q > lim);
        v     = r.sat ? lim : q;
        r.val = neg ? (~v + 32'd1) : v;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/grj_div.sv
// Pipelined restoring divider, one quotient bit per stage, plus overflow flag.
// Depends on nothing; instantiated by gaussian_residual_jacobian.
`default_nettype none
module grj_div #(
    parameter int NW = 64,
    parameter int DW = 45,
    parameter int QW = 32
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QW-1:0] quo,
    output logic               over
);

    localparam int W = (NW > DW + QW) ? NW : DW + QW;

    logic [W-1:0]  rem_reg  [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic [QW-1:0] q_reg    [0:QW];
    logic          over_reg [0:QW];

    logic [W-1:0]  rem_next [1:QW];
    logic [QW-1:0] q_next   [1:QW];
    logic [W-1:0]  trial    [1:QW];
    logic          ge       [1:QW];

    always_comb
    begin
        for (int j = 1; j <= QW; j++)
        begin
            trial[j]    = W'(den_reg[j-1]) << (QW - j);
            ge[j]       = rem_reg[j-1] >= trial[j];
            rem_next[j] = ge[j] ? (rem_reg[j-1] - trial[j]) : rem_reg[j-1];
            q_next[j]   = q_reg[j-1] | (QW'(ge[j]) << (QW - j));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= W'(num);
            den_reg[0]  <= den;
            q_reg[0]    <= '0;
            over_reg[0] <= W'(num) >= (W'(den) << QW);
            for (int j = 1; j <= QW; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                den_reg[j]  <= den_reg[j-1];
                q_reg[j]    <= q_next[j];
                over_reg[j] <= over_reg[j-1];
            end
        end
    end

    assign quo  = q_reg[QW];
    assign over = over_reg[QW];

endmodule
`default_nettype wire

FILE: src/gaussian_residual_jacobian.sv
// Gaussian model weighted residual and Jacobian, streaming top level.
// Depends on grj_pkg and grj_div.
//
// Usage: configuration writes go over cfg_valid/cfg_index/cfg_data
// (cfg_ready is always high) while the block is idle. Points arrive on the
// s_* stream (tdata: sample_x, measured_y, uncertainty; tlast: last point),
// results leave on the m_* stream (tdata: residual, d_amplitude, d_center,
// d_width; tuser: fault; tlast: copy of the last-point flag).
// Throughput: one transfer per cycle while the receiver takes results. The
// delay from an accepted input transfer to the output register is set by
// the z divider (FRAC_BITS + 4 stages) and the four parallel output
// dividers (33 stages), plus the table, multiply and capture stages.
// The whole pipeline advances whenever the output register is empty or
// taken; when the receiver stalls it freezes and s_tready drops, so no
// transfer is lost or repeated.
// Reset clears all valid bits and loads the register defaults (amplitude 1.0,
// center 0, width 1.0, all derivatives enabled). The exponential table is a
// constant built at elaboration.
`default_nettype none
module gaussian_residual_jacobian #(
    parameter int FRAC_BITS         = 16,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // sample_x, measured_y, uncertainty
    input  wire logic         s_tlast,  // last_point
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata,  // residual, d_amplitude, d_center, d_width
    output logic      [1:0]   m_tuser,  // fault
    output logic              m_tlast   // last_out
);

    localparam int TW   = grj_pkg::TAB_W;
    localparam int ZW   = FRAC_BITS + grj_pkg::Z_LIMIT_LOG;
    localparam int Z2W  = ZW + grj_pkg::Z_LIMIT_LOG;
    localparam int NBW  = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int SH   = grj_pkg::EXP_FRAC - FRAC_BITS;
    localparam int MW   = 32 + TW;
    localparam int NRW  = 64;
    localparam int P1W  = MW + ZW;
    localparam int P2W  = MW + Z2W;
    localparam int DENW = 31 + SH;
    localparam int SUW  = 62;
    localparam int D1W  = SUW + SH;
    localparam int QO   = grj_pkg::OUT_W;
    localparam int ZL   = ZW + 1;
    localparam int OL   = QO + 1;

    // series terms of exp(-(8/N)^2 / 2) in Q30
    localparam logic [63:0] EXP_ONE = 64'd1 << grj_pkg::EXP_FRAC;
    localparam logic [63:0] EXP_NN  = 64'(EXP_TABLE_ENTRIES) * 64'(EXP_TABLE_ENTRIES);
    localparam logic [63:0] EXP_T1  = EXP_ONE * 64'd32 / EXP_NN;
    localparam logic [63:0] EXP_T2  = EXP_T1 * 64'd32 / (EXP_NN * 64'd2);
    localparam logic [63:0] EXP_T3  = EXP_T2 * 64'd32 / (EXP_NN * 64'd3);
    localparam logic [63:0] EXP_T4  = EXP_T3 * 64'd32 / (EXP_NN * 64'd4);
    localparam logic [63:0] EXP_T5  = EXP_T4 * 64'd32 / (EXP_NN * 64'd5);
    localparam logic [63:0] EXP_T6  = EXP_T5 * 64'd32 / (EXP_NN * 64'd6);
    localparam logic [63:0] EXP_T7  = EXP_T6 * 64'd32 / (EXP_NN * 64'd7);
    localparam logic [63:0] EXP_T8  = EXP_T7 * 64'd32 / (EXP_NN * 64'd8);
    localparam logic [63:0] EXP_T9  = EXP_T8 * 64'd32 / (EXP_NN * 64'd9);
    localparam logic [63:0] EXP_T10 = EXP_T9 * 64'd32 / (EXP_NN * 64'd10);
    localparam logic [63:0] EXP_T11 = EXP_T10 * 64'd32 / (EXP_NN * 64'd11);
    localparam logic [63:0] EXP_T12 = EXP_T11 * 64'd32 / (EXP_NN * 64'd12);
    localparam logic [63:0] EXP_R   = EXP_ONE - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                      - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                      + EXP_T10 - EXP_T11 + EXP_T12;

    typedef logic [TW-1:0] tab_t [0:EXP_TABLE_ENTRIES];

    function automatic tab_t build_tab();
        tab_t        t;
        logic [63:0] rr;
        logic [63:0] g;
        logic [63:0] v;
        rr   = grj_pkg::rmul30(EXP_R, EXP_R);
        g    = EXP_R;
        v    = EXP_ONE;
        t[0] = TW'(v);
        for (int k = 0; k < EXP_TABLE_ENTRIES; k++)
        begin
            v      = grj_pkg::rmul30(v, g);
            t[k+1] = TW'(v);
            g      = grj_pkg::rmul30(g, rr);
        end
        return t;
    endfunction

    localparam tab_t EXP_TAB = build_tab();

    typedef struct packed {
        logic                valid;
        logic                last;
        logic                upos;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
        logic [30:0]         u;
        logic                dneg;
        logic [31:0]         dmag;
        logic                far;
        logic [ZW-1:0]       zmag;
        logic [NBW-1:0]      k;
        logic [ZW-1:0]       f;
        logic [TW-1:0]       t0;
        logic [TW-1:0]       t1;
        logic [2*ZW-1:0]     sq;
        logic [TW+ZW-1:0]    prod;
        logic [Z2W-1:0]      z2;
        logic [TW-1:0]       e;
        logic [MW-1:0]       mmag;
        logic [SUW-1:0]      su;
        logic [NRW-1:0]      nmag;
        logic                rneg;
        logic [32+ZW-1:0]    p1lo;
        logic [31+ZW-1:0]    p1hi;
        logic [32+Z2W-1:0]   p2lo;
        logic [31+Z2W-1:0]   p2hi;
        logic [P1W-1:0]      p1;
        logic [P2W-1:0]      p2;
    } side_t;

    // configuration
    logic signed [31:0] amplitude_reg;
    logic signed [31:0] center_reg;
    logic [30:0]        width_reg;
    logic [2:0]         deriv_enable_reg;
    logic [30:0]        s_eff;
    logic               aneg;
    logic [31:0]        amag;

    assign cfg_ready = 1'b1;
    assign s_eff     = (width_reg == '0) ? 31'd1 : width_reg;
    assign aneg      = amplitude_reg[31];
    assign amag      = aneg ? (~amplitude_reg + 32'd1) : amplitude_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg    <= 32'sd1 <<< FRAC_BITS;
            center_reg       <= '0;
            width_reg        <= 31'd1 << FRAC_BITS;
            deriv_enable_reg <= 3'd7;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                grj_pkg::REG_AMPLITUDE:    amplitude_reg    <= cfg_data;
                grj_pkg::REG_CENTER:       center_reg       <= cfg_data;
                grj_pkg::REG_WIDTH:        width_reg        <= cfg_data[30:0];
                grj_pkg::REG_DERIV_ENABLE: deriv_enable_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic adv;
    logic ov_reg;

    assign adv      = !ov_reg || m_tready;
    assign s_tready = adv;

    side_t s0_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    side_t s0_next, s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;
    side_t s8_next;
    side_t zd_reg [0:ZL-1];
    side_t od_reg [0:OL-1];

    logic [ZW-1:0] zq;
    logic          zover;
    logic [QO-1:0] rq, aq, cq, wq;
    logic          rover, aover, c_over, wover;

    logic signed [32:0]   dd;
    logic [ZW+NBW-1:0]    pos;
    logic [NBW-1:0]       kp1;
    logic [TW-1:0]        diff;
    logic signed [64:0]   ysh;
    logic signed [64:0]   msg;
    logic signed [64:0]   numr;
    logic [DENW-1:0]      den_u;
    logic [D1W-1:0]       den_su;

    always_comb
    begin
        s0_next       = '0;
        s0_next.valid = s_tvalid;
        s0_next.x     = s_tdata[31:0];
        s0_next.y     = s_tdata[63:32];
        s0_next.u     = s_tdata[94:64];
        s0_next.upos  = !s_tdata[95] && (s_tdata[94:64] != '0);
        s0_next.last  = s_tlast;

        s1_next       = s0_reg;
        dd            = 33'(s0_reg.x) - 33'(center_reg);
        s1_next.dneg  = dd[32];
        s1_next.dmag  = dd[32] ? 32'(-dd) : 32'(dd);

        s2_next       = zd_reg[ZL-1];
        s2_next.far   = zover;
        s2_next.zmag  = zq;
        pos           = (ZW + NBW)'(zq) * (ZW + NBW)'(EXP_TABLE_ENTRIES);
        s2_next.k     = pos[ZW+NBW-1:ZW];
        s2_next.f     = pos[ZW-1:0];

        s3_next       = s2_reg;
        kp1           = s2_reg.k + NBW'(1);
        s3_next.t0    = EXP_TAB[s2_reg.k];
        s3_next.t1    = EXP_TAB[kp1];
        s3_next.sq    = (2*ZW)'(s2_reg.zmag) * (2*ZW)'(s2_reg.zmag);

        s4_next       = s3_reg;
        diff          = (s3_reg.t0 > s3_reg.t1) ? (s3_reg.t0 - s3_reg.t1) : '0;
        s4_next.prod  = (TW+ZW)'(diff) * (TW+ZW)'(s3_reg.f);
        s4_next.z2    = Z2W'(s3_reg.sq >> FRAC_BITS);

        s5_next       = s4_reg;
        s5_next.e     = s4_reg.far ? '0 : (s4_reg.t0 - TW'(s4_reg.prod >> ZW));

        s6_next       = s5_reg;
        s6_next.mmag  = MW'(amag) * MW'(s5_reg.e);
        s6_next.su    = SUW'(s_eff) * SUW'(s5_reg.u);

        s7_next       = s6_reg;
        ysh           = 65'(s6_reg.y) <<< grj_pkg::EXP_FRAC;
        msg           = aneg ? -$signed(65'(s6_reg.mmag)) : $signed(65'(s6_reg.mmag));
        numr          = ysh - msg;
        s7_next.rneg  = numr[64];
        s7_next.nmag  = numr[64] ? NRW'(-numr) : NRW'(numr);
        s7_next.p1lo  = (32+ZW)'(s6_reg.mmag[31:0]) * (32+ZW)'(s6_reg.zmag);
        s7_next.p1hi  = (31+ZW)'(s6_reg.mmag[MW-1:32]) * (31+ZW)'(s6_reg.zmag);
        s7_next.p2lo  = (32+Z2W)'(s6_reg.mmag[31:0]) * (32+Z2W)'(s6_reg.z2);
        s7_next.p2hi  = (31+Z2W)'(s6_reg.mmag[MW-1:32]) * (31+Z2W)'(s6_reg.z2);

        s8_next       = s7_reg;
        s8_next.p1    = (P1W'(s7_reg.p1hi) << 32) + P1W'(s7_reg.p1lo);
        s8_next.p2    = (P2W'(s7_reg.p2hi) << 32) + P2W'(s7_reg.p2lo);

        den_u         = DENW'(s8_reg.u) << SH;
        den_su        = D1W'(s8_reg.su) << SH;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            s4_reg <= '0;
            s5_reg <= '0;
            s6_reg <= '0;
            s7_reg <= '0;
            s8_reg <= '0;
            for (int j = 0; j < ZL; j++)
                zd_reg[j] <= '0;
            for (int j = 0; j < OL; j++)
                od_reg[j] <= '0;
        end
        else if (adv)
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
            zd_reg[0] <= s1_reg;
            for (int j = 1; j < ZL; j++)
                zd_reg[j] <= zd_reg[j-1];
            od_reg[0] <= s8_reg;
            for (int j = 1; j < OL; j++)
                od_reg[j] <= od_reg[j-1];
        end
    end

    grj_div #(.NW(32 + FRAC_BITS), .DW(31), .QW(ZW)) u_zdiv (
        .clk  (clk),
        .en   (adv),
        .num  ({s1_reg.dmag, {FRAC_BITS{1'b0}}}),
        .den  (s_eff),
        .quo  (zq),
        .over (zover)
    );

    grj_div #(.NW(NRW), .DW(DENW), .QW(QO)) u_rdiv (
        .clk  (clk),
        .en   (adv),
        .num  (s8_reg.nmag),
        .den  (den_u),
        .quo  (rq),
        .over (rover)
    );

    grj_div #(.NW(TW + FRAC_BITS), .DW(DENW), .QW(QO)) u_adiv (
        .clk  (clk),
        .en   (adv),
        .num  ({s8_reg.e, {FRAC_BITS{1'b0}}}),
        .den  (den_u),
        .quo  (aq),
        .over (aover)
    );

    grj_div #(.NW(P1W), .DW(D1W), .QW(QO)) u_cdiv (
        .clk  (clk),
        .en   (adv),
        .num  (s8_reg.p1),
        .den  (den_su),
        .quo  (cq),
        .over (c_over)
    );

    grj_div #(.NW(P2W), .DW(D1W), .QW(QO)) u_wdiv (
        .clk  (clk),
        .en   (adv),
        .num  (s8_reg.p2),
        .den  (den_su),
        .quo  (wq),
        .over (wover)
    );

    // output stage
    side_t           od;
    grj_pkg::fin_t   fr, fa, fc, fw;
    logic            sat;
    logic [127:0]    data_reg, data_next;
    logic [1:0]      fault_reg, fault_next;
    logic            last_reg;

    always_comb
    begin
        od  = od_reg[OL-1];
        fr  = grj_pkg::finish(rq, rover, od.rneg);
        fa  = grj_pkg::finish(aq, aover, 1'b1);
        fc  = grj_pkg::finish(cq, c_over, aneg == od.dneg);
        fw  = grj_pkg::finish(wq, wover, !aneg);
        sat = fr.sat || (deriv_enable_reg[0] && fa.sat) ||
              (deriv_enable_reg[1] && fc.sat) || (deriv_enable_reg[2] && fw.sat);
        if (!od.upos)
        begin
            data_next  = '0;
            fault_next = grj_pkg::FAULT_NONPOS;
        end
        else
        begin
            data_next[31:0]   = fr.val;
            data_next[63:32]  = deriv_enable_reg[0] ? fa.val : '0;
            data_next[95:64]  = deriv_enable_reg[1] ? fc.val : '0;
            data_next[127:96] = deriv_enable_reg[2] ? fw.val : '0;
            fault_next        = sat ? grj_pkg::FAULT_SAT : grj_pkg::FAULT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= od.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg  <= data_next;
            fault_reg <= fault_next;
            last_reg  <= od.last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = fault_reg;
    assign m_tlast  = last_reg;

    a_nonpos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == grj_pkg::FAULT_NONPOS |-> m_tdata == '0)
        else $error("nonpositive uncertainty result carries data");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("undefined fault code");

    a_far_no_exp: assert property (@(posedge clk) disable iff (!rst_n)
        s6_reg.valid && s6_reg.far |-> s6_reg.e == '0)
        else $error("far point produced nonzero exponential");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(od_reg[OL-1].valid) && $stable(s0_reg.valid))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for gaussian_residual_jacobian: streams points, predicts
// residual, Jacobian and fault per point and compares every result transfer.
// Depends on grj_pkg and the gaussian_residual_jacobian RTL.
`timescale 1ns / 100ps
module testbench;

    localparam int FRAC        = 16;
    localparam int LUT_N       = 256;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [31:0] residual;
        logic [31:0] d_amp;
        logic [31:0] d_ctr;
        logic [31:0] d_wid;
        logic [1:0]  fault;
        logic        last;
    } point_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // sample_x, measured_y, uncertainty
    logic         s_tlast;   // last_point
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;   // residual, d_amplitude, d_center, d_width
    logic [1:0]   m_tuser;   // fault
    logic         m_tlast;   // last_out

    logic [63:0]   exp_lut [0:LUT_N];
    logic [31:0]   amp_reg;
    logic [31:0]   ctr_reg;
    logic [30:0]   wid_reg;
    logic [2:0]    den_mask;
    point_result_t expected_results[$];
    int            errors;
    int            cycles;
    int            points_sent;
    int            results_seen;
    int            faults_nonpos;
    int            faults_sat;
    int            hold_cycles;
    bit            src_gaps;
    bit            sink_gaps;

    gaussian_residual_jacobian i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [63:0] q30_round_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    task automatic build_exp_lut();
        logic [63:0] nn;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] rr;
        logic [63:0] g;
        nn   = LUT_N * LUT_N;
        term = 64'd1 << 30;
        r    = term;
        for (int i = 1; i <= 12; i++)
        begin
            term = term * 32 / (nn * i);
            if (i % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        rr = q30_round_mul(r, r);
        g  = r;
        exp_lut[0] = 64'd1 << 30;
        for (int k = 0; k < LUT_N; k++)
        begin
            exp_lut[k + 1] = q30_round_mul(exp_lut[k], g);
            g = q30_round_mul(g, rr);
        end
    endtask

    function automatic logic [31:0] clamp_quotient(input logic [127:0] mag, input bit neg,
                                                   input logic [63:0] den, inout bit sat);
        logic [127:0] q;
        logic [127:0] lim;
        q   = mag / den;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
        begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? (~q[31:0] + 32'd1) : q[31:0];
    endfunction

    function automatic point_result_t predict_point(input logic [31:0] x, input logic [31:0] y,
                                                    input logic [31:0] u, input logic last);
        point_result_t r;
        longint        d;
        longint        signed_m;
        longint        num;
        logic [63:0]   s;
        logic [63:0]   dmag;
        logic [63:0]   zmag;
        logic [63:0]   pos;
        logic [63:0]   k;
        logic [63:0]   f;
        logic [63:0]   diff;
        logic [63:0]   e;
        logic [63:0]   z2;
        logic [63:0]   amag;
        logic [63:0]   mmag;
        logic [63:0]   den;
        logic [63:0]   nmag;
        bit            aneg;
        bit            dneg;
        bit            sat;
        r.residual = '0;
        r.d_amp    = '0;
        r.d_ctr    = '0;
        r.d_wid    = '0;
        r.fault    = grj_pkg::FAULT_OK;
        r.last     = last;
        if ($signed(u) <= 0)
        begin
            r.fault = grj_pkg::FAULT_NONPOS;
            return r;
        end
        sat  = 1'b0;
        s    = (wid_reg == 0) ? 64'd1 : 64'(wid_reg);
        d    = longint'($signed(x)) - longint'($signed(ctr_reg));
        dneg = d < 0;
        dmag = dneg ? 64'(-d) : 64'(d);
        zmag = (dmag << FRAC) / s;
        e    = 0;
        z2   = 0;
        if (zmag < (64'd8 << FRAC))
        begin
            pos  = zmag * LUT_N;
            k    = pos / (64'd8 << FRAC);
            f    = pos % (64'd8 << FRAC);
            diff = (exp_lut[k] > exp_lut[k + 1]) ? exp_lut[k] - exp_lut[k + 1] : 0;
            e    = exp_lut[k] - diff * f / (64'd8 << FRAC);
            z2   = (zmag * zmag) >> FRAC;
        end
        aneg     = amp_reg[31];
        amag     = aneg ? 64'(-longint'($signed(amp_reg))) : 64'(amp_reg);
        mmag     = amag * e;
        den      = 64'(u) << (30 - FRAC);
        signed_m = aneg ? -longint'(mmag) : longint'(mmag);
        num      = (longint'($signed(y)) <<< 30) - signed_m;
        nmag     = (num < 0) ? 64'(-num) : 64'(num);
        r.residual = clamp_quotient(128'(nmag), num < 0, den, sat);
        if (den_mask[0])
            r.d_amp = clamp_quotient(128'(e << FRAC), 1'b1, den, sat);
        if (den_mask[1])
            r.d_ctr = clamp_quotient((128'(mmag) * 128'(zmag)) / 128'(s), aneg == dneg, den, sat);
        if (den_mask[2])
            r.d_wid = clamp_quotient((128'(mmag) * 128'(z2)) / 128'(s), !aneg, den, sat);
        if (sat)
            r.fault = grj_pkg::FAULT_SAT;
        return r;
    endfunction

    // Enters and leaves on a rising edge.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] u, input logic last);
        point_result_t r;
        if (src_gaps)
        begin
            while ($urandom_range(99) < 27)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {u, y, x};
        s_tlast  <= last;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        r = predict_point(x, y, u, last);
        expected_results.push_back(r);
        points_sent++;
        if (r.fault == grj_pkg::FAULT_NONPOS)
            faults_nonpos++;
        if (r.fault == grj_pkg::FAULT_SAT)
            faults_sat++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Block must be idle. Writes all four registers back to back.
    task automatic write_config(input logic [31:0] amp, input logic [31:0] ctr,
                                input logic [31:0] wid, input logic [31:0] mask);
        logic [31:0] vals [4];
        logic [7:0]  idxs [4];
        vals = '{amp, ctr, wid, mask};
        idxs = '{grj_pkg::REG_AMPLITUDE, grj_pkg::REG_CENTER, grj_pkg::REG_WIDTH,
                 grj_pkg::REG_DERIV_ENABLE};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data  <= vals[i];
            @(negedge clk);
            while (!cfg_ready)
                @(negedge clk);
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        amp_reg  = amp;
        ctr_reg  = ctr;
        wid_reg  = wid[30:0];
        den_mask = mask[2:0];
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0004_0000);
            2:       return -$urandom_range(0, 32'h0004_0000);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    task automatic send_random_point();
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] u;
        longint      span;
        span = (wid_reg == 0) ? 1 : longint'(wid_reg);
        if ($urandom_range(9) < 8)
            x = ctr_reg + 32'((longint'($urandom_range(0, 2000)) - 1000) * span / 100);
        else
            x = rand_word();
        case ($urandom_range(9))
            0:       u = -$urandom_range(0, 32'h7FFF_FFFF);
            1:       u = 32'd0;
            2:       u = $urandom_range(1, 255);
            3:       u = $urandom;
            4:       u = 32'h7FFF_FFFF;
            default: u = $urandom_range(32'h0000_1000, 32'h0010_0000);
        endcase
        if ($urandom_range(1))
            y = rand_word();
        else
            y = amp_reg + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
        send_point(x, y, u, $urandom_range(15) == 0);
    endtask

    task automatic test_reset_defaults();
        amp_reg  = 32'h0001_0000;
        ctr_reg  = 32'h0;
        wid_reg  = 31'h0001_0000;
        den_mask = 3'd7;
        send_point(32'h0, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0);
        send_point(32'hFFFF_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b1);
        send_point(32'h0008_0000, 32'h0003_0000, 32'h0001_0000, 1'b0);
        drain_results();
    endtask

    task automatic test_directed_corners();
        write_config(32'h0001_0000, 32'h0, 32'h0001_0000, 32'd7);
        send_point(32'h1234_5678, 32'h0001_0000, 32'h0, 1'b1);
        send_point(32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0, 32'h0, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 1'b1);
        send_point(32'h0000_8000, 32'h0, 32'h7FFF_FFFF, 1'b0);
        send_point(32'h0000_4000, 32'h0, 32'h0000_0001, 1'b0);
        drain_results();
        write_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd7);
        send_point(32'h7FFF_FFFF, 32'h0, 32'h0000_0100, 1'b0);
        send_point(32'h7FFF_FFFE, 32'h8000_0000, 32'h0001_0000, 1'b0);
        send_point(32'h8000_0000, 32'h0, 32'h0001_0000, 1'b1);
        drain_results();
        write_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
        send_point(32'h8000_0000, 32'h0, 32'h0000_0010, 1'b0);
        send_point(32'h0, 32'h0, 32'h0000_0010, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1);
        drain_results();
        for (int m = 1; m < 8; m++)
        begin
            write_config(32'hFFFE_0000, 32'h0001_0000, 32'h0000_8000, m);
            send_point(32'h0001_4000, 32'h0, 32'h0000_0400, m[0]);
            send_point(32'h0000_C000, 32'h0, 32'h0000_0002, m[1]);
            drain_results();
        end
    endtask

    task automatic test_random_sweep();
        logic [31:0] amp;
        logic [31:0] wid;
        for (int phase = 0; phase < 10; phase++)
        begin
            amp = (phase % 3 == 0) ? $urandom : rand_word();
            case ($urandom_range(3))
                0:       wid = $urandom;
                1:       wid = $urandom_range(1, 255);
                default: wid = $urandom_range(32'h0000_4000, 32'h0010_0000);
            endcase
            write_config(amp, rand_word(), wid, $urandom_range(7) | ((phase < 4) ? 3'd7 : 3'd0));
            src_gaps  = (phase != 5);
            sink_gaps = (phase != 5);
            for (int n = 0; n < 170; n++)
                send_random_point();
            drain_results();
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    task automatic test_backpressure();
        write_config(32'h0003_0000, 32'hFFFF_8000, 32'h0000_C000, 32'd7);
        hold_cycles = 300;
        for (int n = 0; n < 150; n++)
            send_random_point();
        drain_results();
        for (int n = 0; n < 40; n++)
            send_random_point();
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (sink_gaps)
            m_tready <= ($urandom_range(99) >= 27);
        else
            m_tready <= 1'b1;
    end

    // m_tready only moves at rising edges, so this sees the coming transfer.
    always @(negedge clk)
    begin
        point_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result transfer tdata=%h", $time, m_tdata);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.residual)
                begin
                    errors++;
                    $display("%0t: residual exp %h got %h", $time, exp_r.residual, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== exp_r.d_amp)
                begin
                    errors++;
                    $display("%0t: d_amplitude exp %h got %h", $time, exp_r.d_amp,
                             m_tdata[63:32]);
                end
                if (m_tdata[95:64] !== exp_r.d_ctr)
                begin
                    errors++;
                    $display("%0t: d_center exp %h got %h", $time, exp_r.d_ctr, m_tdata[95:64]);
                end
                if (m_tdata[127:96] !== exp_r.d_wid)
                begin
                    errors++;
                    $display("%0t: d_width exp %h got %h", $time, exp_r.d_wid, m_tdata[127:96]);
                end
                if (m_tuser !== exp_r.fault)
                begin
                    errors++;
                    $display("%0t: fault exp %0d got %0d", $time, exp_r.fault, m_tuser);
                end
                if (m_tlast !== exp_r.last)
                begin
                    errors++;
                    $display("%0t: last exp %b got %b", $time, exp_r.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        errors      = 0;
        cycles      = 0;
        points_sent = 0;
        results_seen  = 0;
        faults_nonpos = 0;
        faults_sat    = 0;
        hold_cycles = 0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        build_exp_lut();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_corners();
        test_random_sweep();
        test_backpressure();
        if (expected_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_results.size());
        end
        $display("Covered %0d points, %0d results: %0d nonpositive-error, %0d saturated.",
                 points_sent, results_seen, faults_nonpos, faults_sat);
        $display("Config sweeps include register extremes, zero width and every derivative mask.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
